[hdl/crfp_pkg.sv]
// Package for the camera result frame parser.
// Holds the frame constants, register indexes and result kind codes.
// No dependencies.
`default_nettype none

package crfp_pkg;

  localparam int CLEAR_LIMIT = 8;
  localparam int STORE_DEPTH = CLEAR_LIMIT + 1;
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int MIN_FRAME   = 4;

  localparam logic [7:0] HEAD_BYTE  = 8'h2C;
  localparam logic [7:0] ID_BYTE    = 8'h12;
  localparam logic [7:0] TAIL_BYTE  = 8'h5B;
  localparam logic [7:0] READY_BYTE = 8'hFF;

  localparam logic REG_PAYLOAD_MODE = 1'b0;
  localparam logic REG_X_OFFSET     = 1'b1;

  localparam logic MODE_BOX   = 1'b0;
  localparam logic MODE_LABEL = 1'b1;

  localparam logic [1:0] KIND_BOX   = 2'd0;
  localparam logic [1:0] KIND_LABEL = 2'd1;
  localparam logic [1:0] KIND_READY = 2'd2;

  typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

[hdl/camera_result_frame_parser.sv]
// Top level of the camera result frame parser.
// Depends on crfp_pkg for frame constants and result kind codes.
//
// Usage: received bytes enter on rx_byte with in_valid; a beat is taken at a
// rising edge where in_valid is high and in_stall is low. Each byte is held
// in an input register and appended to the frame store once it can advance,
// while the frame checks and the payload decode run. A completed valid
// frame yields one result beat on the output channel; other bytes yield none.
// One byte can be accepted in every cycle unless out_stall holds a result.
// When out_stall holds a result, the input register still accepts a byte if
// it is empty, and in_stall rises only while both registers are full.
// The configuration port writes payload_mode (index 0) or x_offset (index 1)
// whenever cfg_we is high; the user must write it only while the parser is
// idle, and the block itself does not enforce this.
// Reset (rst, synchronous) clears the frame store, the byte count, both
// configuration registers and both valid flags.
`default_nettype none

module camera_result_frame_parser
  import crfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [7:0]       label_value,
  output logic [7:0]       box_width,
  output logic [7:0]       box_height,
  output logic signed [9:0] centre_x
);

  logic               payload_mode;
  logic [7:0]         x_offset;
  byte_t              frame_store [STORE_DEPTH];
  byte_t              frame_store_next [STORE_DEPTH];
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic               s1_valid;
  byte_t              s1_byte;

  logic               out_ready;
  logic               advance;
  logic [COUNT_W-1:0] n;
  byte_t              prev_byte;
  logic               long_enough;
  logic               trailer;
  logic               produced;
  logic [1:0]         kind_next;
  logic [7:0]         label_next;
  logic [7:0]         width_next;
  logic [7:0]         height_next;
  logic [9:0]         centre_next;
  byte_t              d1;
  byte_t              d2;
  byte_t              d3;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  assign n = byte_count + COUNT_W'(1);

  always_comb begin
    prev_byte = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      frame_store_next[i] = (COUNT_W'(i) == byte_count) ? s1_byte : frame_store[i];
      if (COUNT_W'(i + 1) == byte_count) begin
        prev_byte = frame_store[i];
      end
    end
  end

  assign d1 = frame_store_next[2];
  assign d2 = frame_store_next[3];
  assign d3 = frame_store_next[4];

  assign long_enough = n >= COUNT_W'(MIN_FRAME);
  assign trailer     = long_enough && (prev_byte == TAIL_BYTE) && (s1_byte == TAIL_BYTE);
  assign produced    = trailer && (frame_store_next[0] == HEAD_BYTE)
                       && (frame_store_next[1] == ID_BYTE);

  always_comb begin
    if ((frame_store_next[0] != HEAD_BYTE) || trailer
        || (long_enough && (n > COUNT_W'(CLEAR_LIMIT)))) begin
      byte_count_next = '0;
    end else begin
      byte_count_next = n;
    end
  end

  always_comb begin
    kind_next   = KIND_READY;
    label_next  = '0;
    width_next  = '0;
    height_next = '0;
    centre_next = '0;
    unique case (payload_mode)
      MODE_BOX: begin
        if ((d1 != READY_BYTE) && (d2 != READY_BYTE) && (d3 != READY_BYTE)) begin
          kind_next   = KIND_BOX;
          width_next  = d2;
          height_next = d3;
          centre_next = {2'b00, d1} - {2'b00, x_offset} + {3'b000, d2[7:1]};
        end
      end
      MODE_LABEL: begin
        if (d1 != READY_BYTE) begin
          kind_next  = KIND_LABEL;
          label_next = d1;
        end
      end
      default: begin
        kind_next = KIND_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_mode <= MODE_BOX;
      x_offset     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAYLOAD_MODE: payload_mode <= cfg_data[0];
        REG_X_OFFSET:     x_offset     <= cfg_data;
        default:          x_offset     <= x_offset;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        frame_store[i] <= '0;
      end
    end else if (advance) begin
      byte_count <= byte_count_next;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        frame_store[i] <= frame_store_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= advance && produced;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produced) begin
      result_kind <= kind_next;
      label_value <= label_next;
      box_width   <= width_next;
      box_height  <= height_next;
      centre_x    <= centre_next;
    end
  end

endmodule

`default_nettype wire

[tb/tb_camera_result_frame_parser.sv]
// Self-checking testbench for the camera result frame parser, with a byte-level frame
// decoder as predictor, randomised idling on both channels and several register settings.
// Depends on crfp_pkg and camera_result_frame_parser only.
`default_nettype none

module tb_camera_result_frame_parser;
  import crfp_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] label;
    logic [7:0] width;
    logic [7:0] height;
    logic [9:0] centre;
  } result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_PAYLOAD_MODE;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] label_value;
  logic [7:0] box_width;
  logic [7:0] box_height;
  logic signed [9:0] centre_x;

  byte_t   rx_bytes_q[$];
  result_t pending_results[$];
  byte_t   frame_mem[STORE_DEPTH];
  int      byte_count = 0;
  logic    cur_mode = MODE_BOX;
  byte_t   cur_offset = 8'h00;
  logic    rx_taken = 1'b0;
  int      rx_idle_pct = 15;
  int      out_stall_pct = 15;
  int      error_count = 0;

  camera_result_frame_parser u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .label_value(label_value), .box_width(box_width),
    .box_height(box_height), .centre_x(centre_x)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_camera_result_frame_parser: errors");
    $finish;
  end

  task automatic decode_byte(input byte_t b);
    int      n;
    logic    trailer;
    int      c;
    result_t r;
    n = byte_count + 1;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    frame_mem[n-1] = b;
    byte_count = n;
    if (frame_mem[0] != HEAD_BYTE) byte_count = 0;
    if (n >= MIN_FRAME) begin
      trailer = (frame_mem[n-2] == TAIL_BYTE) && (frame_mem[n-1] == TAIL_BYTE);
      if (trailer && frame_mem[0] == HEAD_BYTE && frame_mem[1] == ID_BYTE) begin
        r = '0;
        if (cur_mode == MODE_BOX) begin
          if (frame_mem[2] != READY_BYTE && frame_mem[3] != READY_BYTE &&
              frame_mem[4] != READY_BYTE) begin
            c = int'(frame_mem[2]) - int'(cur_offset) + int'(frame_mem[3] >> 1);
            r.kind   = KIND_BOX;
            r.width  = frame_mem[3];
            r.height = frame_mem[4];
            r.centre = c[9:0];
          end else begin
            r.kind = KIND_READY;
          end
        end else if (frame_mem[2] != READY_BYTE) begin
          r.kind  = KIND_LABEL;
          r.label = frame_mem[2];
        end else begin
          r.kind = KIND_READY;
        end
        pending_results.push_back(r);
      end
      if (trailer || n > CLEAR_LIMIT) byte_count = 0;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      error_count++;
      $display("%0t: result beat with none expected, kind %0d", $time, got.kind);
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind) begin
      error_count++;
      $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
    end
    if (got.label !== want.label) begin
      error_count++;
      $display("%0t: label_value expected %0d actual %0d", $time, want.label, got.label);
    end
    if (got.width !== want.width) begin
      error_count++;
      $display("%0t: box_width expected %0d actual %0d", $time, want.width, got.width);
    end
    if (got.height !== want.height) begin
      error_count++;
      $display("%0t: box_height expected %0d actual %0d", $time, want.height, got.height);
    end
    if (got.centre !== want.centre) begin
      error_count++;
      $display("%0t: centre_x expected %0d actual %0d", $time,
               $signed(want.centre), $signed(got.centre));
    end
  endtask

  always @(posedge clk) begin : monitor
    if (rst) begin
      rx_taken <= 1'b0;
    end else begin
      rx_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall)
        check_result({result_kind, label_value, box_width, box_height, centre_x});
      if (in_valid && !in_stall) decode_byte(rx_byte);
    end
  end

  always @(negedge clk) begin : rx_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || rx_taken) begin
      if (rx_bytes_q.size() != 0 && $urandom_range(99) >= rx_idle_pct) begin
        rx_byte  <= rx_bytes_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_stall
    out_stall <= !rst && ($urandom_range(99) < out_stall_pct);
  end

  task automatic wait_idle();
    while (rx_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PAYLOAD_MODE) cur_mode = data[0];
    else cur_offset = data;
  endtask

  task automatic set_mode(input logic mode);
    write_reg(REG_PAYLOAD_MODE, {7'($urandom_range(127)), mode});
  endtask

  task automatic push_bytes(input logic [8*9-1:0] seq, input int len);
    for (int i = 0; i < len; i++) rx_bytes_q.push_back(seq[8*(len-1-i) +: 8]);
  endtask

  function automatic byte_t pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 8) return READY_BYTE;
    if (r < 14) return TAIL_BYTE;
    if (r < 20) return 8'h00;
    if (r < 24) return 8'hFE;
    return 8'($urandom_range(255));
  endfunction

  task automatic push_random(input int nbytes);
    int target;
    int r;
    int k;
    target = rx_bytes_q.size() + nbytes;
    while (rx_bytes_q.size() < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        // Well-formed frame with random payload length and content.
        k = $urandom_range(4);
        rx_bytes_q.push_back(HEAD_BYTE);
        rx_bytes_q.push_back(ID_BYTE);
        repeat (k) rx_bytes_q.push_back(pick_payload());
        rx_bytes_q.push_back(TAIL_BYTE);
        rx_bytes_q.push_back(TAIL_BYTE);
      end else if (r < 78) begin
        // Frame with random bytes after the header and ID and no trailer appended.
        rx_bytes_q.push_back(HEAD_BYTE);
        rx_bytes_q.push_back(ID_BYTE);
        repeat ($urandom_range(5, 8)) rx_bytes_q.push_back(8'($urandom_range(255)));
      end else if (r < 88) begin
        rx_bytes_q.push_back(HEAD_BYTE);
        repeat ($urandom_range(1, 9)) rx_bytes_q.push_back(pick_payload());
      end else begin
        repeat ($urandom_range(1, 4)) rx_bytes_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < STORE_DEPTH; i++) frame_mem[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_mode(MODE_BOX);
    write_reg(REG_X_OFFSET, 8'h00);
    push_bytes({HEAD_BYTE, ID_BYTE, 8'h64, 8'h50, 8'h30, TAIL_BYTE, TAIL_BYTE}, 7);
    push_bytes({HEAD_BYTE, ID_BYTE, TAIL_BYTE, TAIL_BYTE}, 4);
    push_bytes({HEAD_BYTE, ID_BYTE, 8'hFE, 8'hFE, 8'h00, TAIL_BYTE, TAIL_BYTE}, 7);
    push_random(320);
    wait_idle();

    // A long stretch with neither side idling.
    write_reg(REG_X_OFFSET, 8'hFF);
    rx_idle_pct   = 0;
    out_stall_pct = 0;
    push_bytes({HEAD_BYTE, ID_BYTE, 8'h00, 8'h00, 8'h01, TAIL_BYTE, TAIL_BYTE}, 7);
    push_random(320);
    wait_idle();
    rx_idle_pct   = 15;
    out_stall_pct = 15;

    set_mode(MODE_LABEL);
    write_reg(REG_X_OFFSET, 8'($urandom_range(255)));
    push_bytes({HEAD_BYTE, ID_BYTE, READY_BYTE, TAIL_BYTE, TAIL_BYTE}, 5);
    push_random(320);
    wait_idle();

    set_mode(MODE_BOX);
    write_reg(REG_X_OFFSET, 8'($urandom_range(1, 254)));
    push_random(320);
    wait_idle();

    set_mode(MODE_LABEL);
    write_reg(REG_X_OFFSET, 8'h00);
    push_random(320);
    wait_idle();

    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_camera_result_frame_parser: clean");
    end else begin
      $display("tb_camera_result_frame_parser: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
